### rtl/core/sorted_timer_event_queue_core_assert.svh
// Assertion helpers for the sorted timer event queue.
`ifndef SORTED_TIMER_EVENT_QUEUE_CORE_ASSERT_SVH
`define SORTED_TIMER_EVENT_QUEUE_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define STQ_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define STQ_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/stq_pkg.sv
package stq_pkg;

  localparam int unsigned NumEventsDef = 16;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_SERVICE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_LEAVE = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_RSVD  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNLINK,
    ST_FIND,
    ST_INSERT,
    ST_POP_CHECK,
    ST_POP_EMIT,
    ST_STATUS,
    ST_WAIT_OUT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the input item
    logic unlink;    // remove req id from the order list
    logic find_init; // restart insert search
    logic find_step; // advance insert search by one entry
    logic insert;    // place the new id at the search position
    logic pop;       // drop the head entry, emit a notice
    logic status;    // emit the status item
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic     add_ok;     // add request with valid arguments
    logic     rem_ok;     // remove request with valid id
    logic     svc;        // service request
    logic     find_done;  // insert position found
    logic     head_due;   // queue not empty and head expiry <= now
    logic     out_busy;   // output register still holds a result
  } stat_t;

endpackage

### rtl/core/stq_ctrl.sv
module stq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           running,
  input  stq_pkg::stat_t st,
  output stq_pkg::cmd_t  cmd
);

  stq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      stq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = stq_pkg::ST_UNLINK;
        end
      end
      stq_pkg::ST_UNLINK: begin
        if (st.add_ok || st.rem_ok) begin
          cmd.unlink = 1'b1;
        end
        if (st.add_ok) begin
          cmd.find_init = 1'b1;
          state_nxt     = stq_pkg::ST_FIND;
        end else if ((st.rem_ok || st.svc) && running) begin
          state_nxt = stq_pkg::ST_POP_CHECK;
        end else begin
          state_nxt = stq_pkg::ST_STATUS;
        end
      end
      stq_pkg::ST_FIND: begin
        if (st.find_done) begin
          state_nxt = stq_pkg::ST_INSERT;
        end else begin
          cmd.find_step = 1'b1;
        end
      end
      stq_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = running ? stq_pkg::ST_POP_CHECK : stq_pkg::ST_STATUS;
      end
      stq_pkg::ST_POP_CHECK: begin
        state_nxt = st.head_due ? stq_pkg::ST_POP_EMIT : stq_pkg::ST_STATUS;
      end
      stq_pkg::ST_POP_EMIT: begin
        if (!st.out_busy) begin
          cmd.pop   = 1'b1;
          state_nxt = stq_pkg::ST_POP_CHECK;
        end
      end
      stq_pkg::ST_STATUS: begin
        if (!st.out_busy) begin
          cmd.status = 1'b1;
          state_nxt  = stq_pkg::ST_IDLE;
        end
      end
      stq_pkg::ST_WAIT_OUT: begin
        state_nxt = stq_pkg::ST_IDLE;
      end
      default: state_nxt = stq_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/core/stq_datapath.sv
module stq_datapath #(
  parameter int unsigned NumEvents = stq_pkg::NumEventsDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           running,
  input  logic [1:0]     in_opcode,
  input  logic [3:0]     in_event_id,
  input  logic [1:0]     in_event_kind,
  input  logic [63:0]    in_delay,
  input  logic [63:0]    in_now,
  input  stq_pkg::cmd_t  cmd,
  output stq_pkg::stat_t st,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic           out_item_kind,
  output logic [3:0]     out_fired_id,
  output logic [1:0]     out_fired_kind,
  output logic           out_status,
  output logic [1:0]     out_timer_action,
  output logic [63:0]    out_timer_value,
  output logic [63:0]    out_next_expire,
  output logic [4:0]     out_queued_count,
  output logic           out_last
);

  localparam int unsigned IdxW = (NumEvents > 1) ? $clog2(NumEvents) : 1;
  localparam int unsigned CntW = $clog2(NumEvents + 1);

  logic [1:0]  op_r;
  logic [3:0]  id_r;
  logic [1:0]  kind_r;
  logic        dly_zero_r;
  logic [63:0] now_r;
  logic [63:0] exp_r;

  logic [NumEvents-1:0] valid_r;
  logic [63:0]          expiry_r [NumEvents];
  logic [1:0]           skind_r  [NumEvents];
  logic [IdxW-1:0]      order_r  [NumEvents];
  logic [CntW-1:0]      occ_r;
  logic [CntW-1:0]      pos_r;

  logic id_ok;
  logic [IdxW-1:0] id_ix, head_ix;
  logic [63:0] head_exp;
  logic [CntW-1:0] unl_pos;
  logic unl_hit;

  assign id_ok   = {28'd0, id_r} < 32'(NumEvents);
  assign id_ix   = IdxW'(id_r);
  assign head_ix = order_r[0];
  assign head_exp = expiry_r[head_ix];

  // Position of the id in the order list (independent compares).
  always_comb begin
    unl_pos = '0;
    unl_hit = 1'b0;
    for (int i = NumEvents - 1; i >= 0; i--) begin
      if (CntW'(i) < occ_r && order_r[i] == id_ix) begin
        unl_pos = CntW'(i);
        unl_hit = 1'b1;
      end
    end
  end

  assign st.add_ok    = (op_r == stq_pkg::OP_ADD) && !dly_zero_r && id_ok;
  assign st.rem_ok    = (op_r == stq_pkg::OP_REMOVE) && id_ok;
  assign st.svc       = (op_r == stq_pkg::OP_SERVICE);
  assign st.find_done = (pos_r >= occ_r) || (expiry_r[order_r[pos_r[IdxW-1:0]]] > exp_r);
  assign st.head_due  = (occ_r != '0) && (head_exp <= now_r);
  assign st.out_busy  = out_tvalid && !out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_opcode;
      id_r       <= in_event_id;
      kind_r     <= in_event_kind;
      dly_zero_r <= (in_delay == 64'd0);
      now_r      <= in_now;
      exp_r      <= in_now + in_delay;
    end
    if (cmd.find_init) begin
      pos_r <= '0;
    end else if (cmd.find_step) begin
      pos_r <= pos_r + 1'b1;
    end
  end

  // Order list and slot store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (cmd.unlink) begin
      if (valid_r[id_ix]) begin
        if (unl_hit) begin
          for (int i = 0; i < NumEvents - 1; i++) begin
            if (CntW'(i) >= unl_pos) begin
              order_r[i] <= order_r[i+1];
            end
          end
          occ_r <= occ_r - 1'b1;
        end
        valid_r[id_ix] <= 1'b0;
      end
    end else if (cmd.insert) begin
      if (occ_r < CntW'(NumEvents)) begin
        for (int i = 1; i < NumEvents; i++) begin
          if (CntW'(i) > pos_r && CntW'(i) <= occ_r) begin
            order_r[i] <= order_r[i-1];
          end
        end
        order_r[pos_r[IdxW-1:0]] <= id_ix;
        expiry_r[id_ix] <= exp_r;
        skind_r[id_ix]  <= kind_r;
        valid_r[id_ix]  <= 1'b1;
        occ_r <= occ_r + 1'b1;
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < NumEvents - 1; i++) begin
        order_r[i] <= order_r[i+1];
      end
      occ_r <= occ_r - 1'b1;
      valid_r[head_ix] <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.pop || cmd.status) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_item_kind    <= 1'b0;
      out_fired_id     <= 4'(head_ix);
      out_fired_kind   <= skind_r[head_ix];
      out_status       <= 1'b0;
      out_timer_action <= stq_pkg::ACT_LEAVE;
      out_timer_value  <= '0;
      out_next_expire  <= '0;
      out_queued_count <= '0;
      out_last         <= 1'b0;
    end else if (cmd.status) begin
      out_item_kind    <= 1'b1;
      out_fired_id     <= '0;
      out_fired_kind   <= '0;
      out_status       <= (op_r == stq_pkg::OP_ADD && (dly_zero_r || !id_ok)) ||
                          (op_r == stq_pkg::OP_REMOVE && !id_ok);
      out_queued_count <= 5'(occ_r);
      out_next_expire  <= (occ_r != '0) ? head_exp : 64'd0;
      out_last         <= 1'b1;
      if (running && (st.add_ok || st.rem_ok || st.svc)) begin
        out_timer_action <= (occ_r == '0) ? stq_pkg::ACT_STOP : stq_pkg::ACT_LOAD;
        out_timer_value  <= (occ_r == '0) ? 64'd0 : head_exp - now_r;
      end else begin
        out_timer_action <= stq_pkg::ACT_LEAVE;
        out_timer_value  <= '0;
      end
    end
  end

  `include "sorted_timer_event_queue_core_assert.svh"

  `STQ_ASSERT_IMPL(a_occ_range, clk, rst_n, 1'b1, occ_r <= CntW'(NumEvents), "occupancy overflow")
  `STQ_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, cmd.pop, occ_r != '0, "pop from empty queue")
  `STQ_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.pop || cmd.status, out_tvalid, "result lost")
  `STQ_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.pop || cmd.status, !st.out_busy, "result overwritten")

endmodule

### rtl/core/sorted_timer_event_queue_core.sv
// Sorted timer event queue: keeps up to NUM_EVENTS timer events in expiry order
// (ties in insertion order) and serves add, remove and expire-service requests.
// Every request yields one notice per popped event followed by a status item
// with tlast high. One request is worked on at a time: a valid add or remove
// first unlinks its id, and an add then runs a serial insert search that
// passes over one queued entry at a time before it inserts the event.
// While running, a valid add, a valid remove or a service then pops due
// events one entry at a time; invalid requests, unused opcodes and requests
// while stopped go straight to the status item. A stalled receiver holds
// the pop loop and the status item until the output register is free.
module sorted_timer_event_queue_core #(
  parameter int unsigned NUM_EVENTS = stq_pkg::NumEventsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,     // running
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,      // [1:0] opcode
  // [3:0] event_id, [5:4] event_kind, [69:6] delay, [133:70] now,
  // [135:134] zero fill
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tuser,     // [0] item_kind
  // [3:0] fired_id, [5:4] fired_kind, [6] status, [8:7] timer_action,
  // [72:9] timer_value, [136:73] next_expire, [141:137] queued_count,
  // [143:142] zero fill
  output logic [143:0] out_tdata,
  output logic         out_tlast
);

  logic           running_r;
  stq_pkg::cmd_t  cmd;
  stq_pkg::stat_t st;
  logic           status;
  logic [3:0]     fired_id;
  logic [1:0]     fired_kind, action;
  logic [63:0]    tval, nexp;
  logic [4:0]     qcnt;

  // Hold the running flag; the user keeps it written only while idle (no check here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else if (cfg_we) begin
      running_r <= cfg_wdata;
    end
  end

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .running   (running_r),
    .st        (st),
    .cmd       (cmd)
  );

  stq_datapath #(.NumEvents(NUM_EVENTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .running          (running_r),
    .in_opcode        (in_tuser),
    .in_event_id      (in_tdata[3:0]),
    .in_event_kind    (in_tdata[5:4]),
    .in_delay         (in_tdata[69:6]),
    .in_now           (in_tdata[133:70]),
    .cmd              (cmd),
    .st               (st),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_item_kind    (out_tuser),
    .out_fired_id     (fired_id),
    .out_fired_kind   (fired_kind),
    .out_status       (status),
    .out_timer_action (action),
    .out_timer_value  (tval),
    .out_next_expire  (nexp),
    .out_queued_count (qcnt),
    .out_last         (out_tlast)
  );

  assign out_tdata = {2'b00, qcnt, nexp, tval, action, status, fired_kind, fired_id};

endmodule
